@@ sv/vmlp_pkg.sv @@
// Types and constants shared by the video memory layout planner.
package vmlp_pkg;

   // Internal address width: every legal address and sum stays below 2**30.
   localparam int unsigned ADDR_W = 30;
   localparam int unsigned NUM_COLOR = 4;

   typedef logic [ADDR_W-1:0] addr_type;

   localparam logic [2:0] MAX_COLOR_BUFFERS = 3'd4;
   localparam addr_type MIN_TEXTURE_BYTES = ADDR_W'(2097152);
   localparam addr_type MIN_FIFO_BYTES = ADDR_W'(65536);
   localparam addr_type FIFO_BYTES_SMALL = ADDR_W'(131072);
   localparam addr_type FIFO_BYTES_LARGE = ADDR_W'(262144);
   localparam addr_type FIFO_RESERVE_BYTES = ADDR_W'(8192);
   localparam addr_type PAGE_BYTES = ADDR_W'(4096);
   localparam int unsigned PAGE_BIT = 12;
   localparam logic [31:0] VRAM_MIN = 32'h0010_0000;
   localparam logic [31:0] VRAM_MAX = 32'h1000_0000;
   localparam logic [31:0] VRAM_LARGE = 32'h0080_0000;
   localparam logic [11:0] RES_MAX = 12'd2048;

   typedef struct packed {
      logic [31:0] vram_bytes;
      logic [31:0] desktop_end;
      logic [11:0] width_pixels;
      logic [11:0] height_lines;
      logic [2:0]  color_count;
      logic [1:0]  aux_count;
      logic [28:0] min_texture_bytes;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [12:0] row_stride;
      logic [24:0] buffer_bytes;
      logic [27:0] texture_offset;
      logic [28:0] texture_bytes;
      logic [27:0] fifo_offset;
      logic [28:0] fifo_bytes;
      logic [27:0] aux_offset;
      logic [27:0] color_offset_0;
      logic [27:0] color_offset_1;
      logic [27:0] color_offset_2;
      logic [27:0] color_offset_3;
   } rsp_type;

   // Working record that travels down the pipeline.
   typedef struct packed {
      logic                          fail;
      addr_type                      vram;
      addr_type                      desk;
      logic [12:0]                   stride;
      logic [24:0]                   buf_bytes;
      logic [3:0]                    cnt;
      logic [2:0]                    ncol;
      logic                          aux_en;
      logic [28:0]                   mintex;
      addr_type                      tram;
      logic                          fifo_big;
      logic [28:0]                   need;
      addr_type                      top;
      addr_type                      aux;
      logic [NUM_COLOR-1:0][ADDR_W-1:0] col;
      addr_type                      fifo;
      addr_type                      texsz;
      addr_type                      s_tm;
      addr_type                      s_tf;
      addr_type                      fifo_off;
      addr_type                      fifo_len;
      addr_type                      aux_end;
      logic [NUM_COLOR-1:0][ADDR_W-1:0] col_end;
   } plan_type;

endpackage

@@ sv/video_memory_layout_planner_unit.sv @@
// Video memory layout planner: one request in, one memory plan out, through a
// 12-stage pipeline (3 check stages, 5 allocation stages, 2 FIFO sizing stages,
// 2 closing stages). An item enters every cycle unless the pipeline is held, and
// its plan moves through the register stages in order to the output; the
// whole pipeline holds while a finished plan is stalled at the output.
module video_memory_layout_planner_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vmlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vmlp_pkg::rsp_type rsp_data
);

   logic               advance;
   logic               v_front, v_aux, v_c3, v_c2, v_c1, v_c0, v_fifo;
   vmlp_pkg::plan_type p_front, p_aux, p_c3, p_c2, p_c1, p_c0, p_fifo;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   vmlp_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .in_req(req_data),
      .out_valid(v_front), .out_plan(p_front)
   );

   vmlp_alloc #(.AUX_SLOT(1'b1), .IDX(0)) u_alloc_aux (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_front), .in_plan(p_front),
      .out_valid(v_aux), .out_plan(p_aux)
   );

   vmlp_alloc #(.AUX_SLOT(1'b0), .IDX(3)) u_alloc_c3 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_aux), .in_plan(p_aux),
      .out_valid(v_c3), .out_plan(p_c3)
   );

   vmlp_alloc #(.AUX_SLOT(1'b0), .IDX(2)) u_alloc_c2 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_c3), .in_plan(p_c3),
      .out_valid(v_c2), .out_plan(p_c2)
   );

   vmlp_alloc #(.AUX_SLOT(1'b0), .IDX(1)) u_alloc_c1 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_c2), .in_plan(p_c2),
      .out_valid(v_c1), .out_plan(p_c1)
   );

   vmlp_alloc #(.AUX_SLOT(1'b0), .IDX(0)) u_alloc_c0 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_c1), .in_plan(p_c1),
      .out_valid(v_c0), .out_plan(p_c0)
   );

   vmlp_fifo u_fifo (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_c0), .in_plan(p_c0),
      .out_valid(v_fifo), .out_plan(p_fifo)
   );

   vmlp_close u_close (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_fifo), .in_plan(p_fifo),
      .out_valid(rsp_valid), .out_rsp(rsp_data)
   );

endmodule

@@ sv/vmlp_front.sv @@
// Front stages: range checks, buffer size product and minimum memory check.
module vmlp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  vmlp_pkg::req_type in_req,
   output logic              out_valid,
   output vmlp_pkg::plan_type out_plan
);

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   vmlp_pkg::plan_type s1_ff, s2_ff, s3_ff;
   vmlp_pkg::plan_type s1_in, s2_in, s3_in;
   logic [32:0]        tram_wide;
   logic [30:0]        min_sum;

   always_comb begin
      s1_in = '0;
      s1_in.fail = (in_req.width_pixels == 12'd0) || (in_req.height_lines == 12'd0) ||
                   (in_req.width_pixels > vmlp_pkg::RES_MAX) ||
                   (in_req.height_lines > vmlp_pkg::RES_MAX) ||
                   (in_req.color_count == 3'd0) ||
                   (in_req.color_count > vmlp_pkg::MAX_COLOR_BUFFERS) ||
                   (in_req.aux_count > 2'd1) ||
                   (in_req.vram_bytes < vmlp_pkg::VRAM_MIN) ||
                   (in_req.vram_bytes > vmlp_pkg::VRAM_MAX) ||
                   (in_req.desktop_end > in_req.vram_bytes);
      s1_in.vram = in_req.vram_bytes[vmlp_pkg::ADDR_W-1:0];
      s1_in.desk = in_req.desktop_end[vmlp_pkg::ADDR_W-1:0];
      s1_in.stride = {in_req.width_pixels, 1'b0};
      s1_in.buf_bytes = {12'b0, s1_in.stride} * {13'b0, in_req.height_lines};
      tram_wide = {1'b0, in_req.desktop_end} + 33'h0_0000_0FFF;
      s1_in.tram = {tram_wide[vmlp_pkg::ADDR_W-1:vmlp_pkg::PAGE_BIT],
                    vmlp_pkg::PAGE_BIT'(0)};
      s1_in.mintex = (in_req.min_texture_bytes == 29'd0) ?
                     vmlp_pkg::MIN_TEXTURE_BYTES[28:0] : in_req.min_texture_bytes;
      s1_in.ncol = in_req.color_count;
      s1_in.aux_en = in_req.aux_count[0];
      s1_in.cnt = {1'b0, in_req.color_count} + {2'b0, in_req.aux_count};
      s1_in.fifo_big = in_req.vram_bytes > vmlp_pkg::VRAM_LARGE;
   end

   always_comb begin
      s2_in = s1_ff;
      s2_in.need = {4'b0, s1_ff.buf_bytes} * {25'b0, s1_ff.cnt};
   end

   always_comb begin
      s3_in = s2_ff;
      min_sum = {2'b0, s2_ff.need} + {1'b0, vmlp_pkg::MIN_TEXTURE_BYTES} +
                {1'b0, vmlp_pkg::MIN_FIFO_BYTES} + {1'b0, s2_ff.desk};
      s3_in.fail = s2_ff.fail || (min_sum > {1'b0, s2_ff.vram});
      s3_in.top = s2_ff.vram;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_plan = s3_ff;

endmodule

@@ sv/vmlp_alloc.sv @@
// One top-down allocation stage: places the aux buffer or one color buffer.
module vmlp_alloc #(
   parameter bit AUX_SLOT = 1'b0,
   parameter int unsigned IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  vmlp_pkg::plan_type in_plan,
   output logic               out_valid,
   output vmlp_pkg::plan_type out_plan
);

   localparam logic [1:0] SLOT = IDX[1:0];

   logic               valid_ff;
   vmlp_pkg::plan_type plan_ff, plan_in;
   vmlp_pkg::addr_type need, t;
   logic               active;

   always_comb begin
      plan_in = in_plan;
      active = AUX_SLOT ? in_plan.aux_en : ({1'b0, SLOT} < in_plan.ncol);
      need = {5'b0, in_plan.buf_bytes} + vmlp_pkg::PAGE_BYTES;
      t = in_plan.top - {5'b0, in_plan.buf_bytes};
      // aux sits on an odd page, color buffers on even pages
      if (t[vmlp_pkg::PAGE_BIT] != AUX_SLOT) begin
         t = t - vmlp_pkg::PAGE_BYTES;
      end
      if (active) begin
         plan_in.fail = in_plan.fail || (in_plan.top < need);
         plan_in.top = t;
         if (AUX_SLOT) begin
            plan_in.aux = t;
         end else begin
            plan_in.col[SLOT] = t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         plan_ff <= plan_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_plan = plan_ff;

endmodule

@@ sv/vmlp_fifo.sv @@
// Two stages that size the texture area and the command FIFO.
module vmlp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  vmlp_pkg::plan_type in_plan,
   output logic               out_valid,
   output vmlp_pkg::plan_type out_plan
);

   logic               f1_valid_ff, f2_valid_ff;
   vmlp_pkg::plan_type f1_ff, f2_ff, f1_in, f2_in;
   vmlp_pkg::addr_type fb;
   logic               shrink;

   always_comb begin
      f1_in = in_plan;
      f1_in.fifo = in_plan.fifo_big ? vmlp_pkg::FIFO_BYTES_LARGE :
                                      vmlp_pkg::FIFO_BYTES_SMALL;
      f1_in.s_tm = in_plan.tram + {1'b0, in_plan.mintex};
      f1_in.s_tf = in_plan.tram + f1_in.fifo;
   end

   always_comb begin
      f2_in = f1_ff;
      fb = f1_ff.col[0];
      // texture would fall below its minimum: FIFO gives way
      shrink = fb < (f1_ff.s_tm + f1_ff.fifo);
      if (shrink) begin
         f2_in.fail = f1_ff.fail || (fb < f1_ff.s_tm);
         f2_in.fifo = fb - f1_ff.s_tm;
         f2_in.texsz = {1'b0, f1_ff.mintex};
      end else begin
         f2_in.texsz = fb - f1_ff.s_tf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

   assign out_valid = f2_valid_ff;
   assign out_plan = f2_ff;

endmodule

@@ sv/vmlp_close.sv @@
// Final stages: FIFO placement, overlap check and the result register.
module vmlp_close (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  vmlp_pkg::plan_type in_plan,
   output logic               out_valid,
   output vmlp_pkg::rsp_type  out_rsp
);

   logic               a_valid_ff, b_valid_ff;
   vmlp_pkg::plan_type a_ff, a_in;
   vmlp_pkg::rsp_type  b_ff, b_in;
   logic               bad;
   vmlp_pkg::addr_type prev_end;

   always_comb begin
      a_in = in_plan;
      a_in.fail = in_plan.fail ||
                  (in_plan.fifo < (vmlp_pkg::FIFO_RESERVE_BYTES + vmlp_pkg::PAGE_BYTES));
      a_in.fifo_off = in_plan.col[0] - in_plan.fifo;
      a_in.fifo_len = in_plan.fifo - vmlp_pkg::FIFO_RESERVE_BYTES;
      for (int i = 0; i < vmlp_pkg::NUM_COLOR; i++) begin
         a_in.col_end[i] = in_plan.col[i] + {5'b0, in_plan.buf_bytes};
      end
      a_in.aux_end = in_plan.aux + {5'b0, in_plan.buf_bytes};
   end

   always_comb begin
      bad = a_ff.fail || (a_ff.tram < a_ff.desk) ||
            (a_ff.fifo_off < (a_ff.tram + a_ff.texsz)) ||
            (a_ff.col[0] < (a_ff.fifo_off + a_ff.fifo));
      prev_end = a_ff.col[0];
      for (int i = 0; i < vmlp_pkg::NUM_COLOR; i++) begin
         if (3'(i) < a_ff.ncol) begin
            if (a_ff.col[i][vmlp_pkg::PAGE_BIT]) bad = 1'b1;
            if ((i > 0) && (a_ff.col[i] < prev_end)) bad = 1'b1;
            prev_end = a_ff.col_end[i];
         end
      end
      if (a_ff.aux_en) begin
         if (!a_ff.aux[vmlp_pkg::PAGE_BIT]) bad = 1'b1;
         if (a_ff.aux < prev_end) bad = 1'b1;
         prev_end = a_ff.aux_end;
      end
      if (prev_end > a_ff.vram) bad = 1'b1;

      b_in = '0;
      if (!bad) begin
         b_in.ok = 1'b1;
         b_in.row_stride = a_ff.stride;
         b_in.buffer_bytes = a_ff.buf_bytes;
         b_in.texture_offset = a_ff.tram[27:0];
         b_in.texture_bytes = a_ff.texsz[28:0];
         b_in.fifo_offset = a_ff.fifo_off[27:0];
         b_in.fifo_bytes = a_ff.fifo_len[28:0];
         b_in.aux_offset = a_ff.aux[27:0];
         b_in.color_offset_0 = a_ff.col[0][27:0];
         b_in.color_offset_1 = a_ff.col[1][27:0];
         b_in.color_offset_2 = a_ff.col[2][27:0];
         b_in.color_offset_3 = a_ff.col[3][27:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rsp = b_ff;

endmodule
